[rtl/core/assert_macros.svh]
// Assertion macros shared by the mixer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define JDDM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define JDDM_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define JDDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/jddm_pkg.sv]
// Shared types and constants of the joystick differential drive mixer.
package jddm_pkg;

    localparam int RAW_W      = 8;
    localparam int AXIS_W     = 8;
    localparam int MOTOR_W    = 9;
    localparam int LEVEL_W    = 7;
    localparam int PORT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    // Axis shaping thresholds, compared against the centered magnitude.
    localparam logic [RAW_W:0] AXIS_CENTER  = 9'd128;
    localparam logic [RAW_W:0] DEAD_ZONE    = 9'd8;
    localparam logic [RAW_W:0] DOUBLE_LIMIT = 9'd20;

    // Action level range and reset point.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd50;

    // Clamp limit for mixed drive values.
    localparam logic signed [MOTOR_W-1:0] DRIVE_LIMIT = 9'sd100;

    // Motor output selectors.
    localparam logic [PORT_W-1:0] PORT_A = 2'd0;
    localparam logic [PORT_W-1:0] PORT_B = 2'd1;
    localparam logic [PORT_W-1:0] PORT_C = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTROL_MODE      = 3'd0,
        CFG_SINGLE_MODE       = 3'd1,
        CFG_REVERSE_SECOND    = 3'd2,
        CFG_FIRST_DRIVE_PORT  = 3'd3,
        CFG_SECOND_DRIVE_PORT = 3'd4,
        CFG_ACTION_PORT       = 3'd5
    } cfg_idx_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic              control_mode;
        logic              single_mode;
        logic              reverse_second;
        logic [PORT_W-1:0] first_drive_port;
        logic [PORT_W-1:0] second_drive_port;
        logic [PORT_W-1:0] action_port;
    } cfg_t;

    // Button group of one sample.
    typedef struct packed {
        logic key_down;
        logic key_up;
        logic key_reverse;
        logic key_forward;
    } keys_t;

endpackage

[rtl/core/jddm_cfg_regs.sv]
// Configuration register file of the mixer.
module jddm_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jddm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jddm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output jddm_pkg::cfg_t                   cfg
);

    jddm_pkg::cfg_t cfg_reg;
    jddm_pkg::cfg_t cfg_next;

    // Writes always complete in the cycle they are requested.
    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (jddm_pkg::cfg_idx_t'(cfg_index))
                jddm_pkg::CFG_CONTROL_MODE:      cfg_next.control_mode      = cfg_data[0];
                jddm_pkg::CFG_SINGLE_MODE:       cfg_next.single_mode       = cfg_data[0];
                jddm_pkg::CFG_REVERSE_SECOND:    cfg_next.reverse_second    = cfg_data[0];
                jddm_pkg::CFG_FIRST_DRIVE_PORT:  cfg_next.first_drive_port  = cfg_data;
                jddm_pkg::CFG_SECOND_DRIVE_PORT: cfg_next.second_drive_port = cfg_data;
                jddm_pkg::CFG_ACTION_PORT:       cfg_next.action_port       = cfg_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_mode      <= 1'b0;
            cfg_reg.single_mode       <= 1'b0;
            cfg_reg.reverse_second    <= 1'b0;
            cfg_reg.first_drive_port  <= jddm_pkg::PORT_A;
            cfg_reg.second_drive_port <= jddm_pkg::PORT_B;
            cfg_reg.action_port       <= jddm_pkg::PORT_C;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/jddm_shape.sv]
// Axis shaping: centering, dead zone and small-deflection doubling.
module jddm_shape
(
    input  logic [jddm_pkg::RAW_W-1:0]         raw,
    input  logic                               tilt,
    output logic signed [jddm_pkg::AXIS_W-1:0] shaped
);

    logic signed [jddm_pkg::RAW_W:0] centered;
    logic        [jddm_pkg::RAW_W:0] mag;
    logic signed [jddm_pkg::RAW_W:0] doubled;

    // Center around zero and take the magnitude; -128 gives 128, which fits.
    assign centered = signed'({1'b0, raw} - jddm_pkg::AXIS_CENTER);
    assign mag      = centered[jddm_pkg::RAW_W] ? unsigned'(-centered) : unsigned'(centered);
    assign doubled  = centered <<< 1;

    // Small deflections are doubled; the doubled range stays within 8 bits.
    always_comb
    begin
        if (tilt || (mag < jddm_pkg::DEAD_ZONE))
        begin
            shaped = '0;
        end
        else if (mag < jddm_pkg::DOUBLE_LIMIT)
        begin
            shaped = doubled[jddm_pkg::AXIS_W-1:0];
        end
        else
        begin
            shaped = centered[jddm_pkg::AXIS_W-1:0];
        end
    end

endmodule

[rtl/core/jddm_action.sv]
// Action level and latched action drive, updated once per sample.
`include "assert_macros.svh"

module jddm_action
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 tilt,
    input  jddm_pkg::keys_t                      keys,
    output logic [jddm_pkg::LEVEL_W-1:0]         level_now,
    output logic signed [jddm_pkg::AXIS_W-1:0]   drive_now
);

    logic        [jddm_pkg::LEVEL_W-1:0] level_reg;
    logic        [jddm_pkg::LEVEL_W-1:0] level_next;
    logic signed [jddm_pkg::AXIS_W-1:0]  drive_reg;
    logic signed [jddm_pkg::AXIS_W-1:0]  drive_next;
    logic signed [jddm_pkg::AXIS_W-1:0]  level_signed;

    // Level steps down or up with saturation; the down key wins.
    always_comb
    begin
        level_next = level_reg;
        if (!tilt)
        begin
            if (keys.key_down)
            begin
                if (level_reg != '0)
                begin
                    level_next = level_reg - 1'b1;
                end
            end
            else if (keys.key_up)
            begin
                if (level_reg < jddm_pkg::LEVEL_MAX)
                begin
                    level_next = level_reg + 1'b1;
                end
            end
        end
    end

    assign level_signed = signed'({1'b0, level_next});

    // Drive latches to minus or plus the new level; the reverse key wins.
    always_comb
    begin
        drive_next = drive_reg;
        if (!tilt)
        begin
            if (keys.key_reverse)
            begin
                drive_next = -level_signed;
            end
            else if (keys.key_forward)
            begin
                drive_next = level_signed;
            end
        end
    end

    assign level_now = level_next;
    assign drive_now = drive_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= jddm_pkg::LEVEL_RESET;
            drive_reg <= '0;
        end
        else if (advance)
        begin
            level_reg <= level_next;
            drive_reg <= drive_next;
        end
    end

    `JDDM_ASSERT_ALWAYS(a_level_range, level_reg <= jddm_pkg::LEVEL_MAX, "action level above maximum")
    `JDDM_ASSERT_ALWAYS(a_drive_range, (drive_reg >= -8'sd100) && (drive_reg <= 8'sd100), "action drive out of range")
    `JDDM_ASSERT_NEXT(a_hold_idle, !advance, $stable(level_reg) && $stable(drive_reg), "state changed without a sample")
    `JDDM_ASSERT_NEXT(a_hold_tilt, advance && tilt, $stable(level_reg) && $stable(drive_reg), "state changed in tilt mode")

endmodule

[rtl/core/jddm_mix.sv]
// Drive mixing, clamping, second-drive reversal and motor routing.
module jddm_mix
(
    input  logic signed [jddm_pkg::AXIS_W-1:0]  x,
    input  logic signed [jddm_pkg::AXIS_W-1:0]  y,
    input  logic signed [jddm_pkg::AXIS_W-1:0]  drive,
    input  jddm_pkg::cfg_t                      cfg,
    output logic signed [jddm_pkg::MOTOR_W-1:0] motor_a,
    output logic signed [jddm_pkg::MOTOR_W-1:0] motor_b,
    output logic signed [jddm_pkg::MOTOR_W-1:0] motor_c
);

    logic signed [jddm_pkg::MOTOR_W-1:0] xe;
    logic signed [jddm_pkg::MOTOR_W-1:0] ye;
    logic signed [jddm_pkg::MOTOR_W-1:0] de;
    logic signed [jddm_pkg::MOTOR_W-1:0] sum;
    logic signed [jddm_pkg::MOTOR_W-1:0] diff;
    logic signed [jddm_pkg::MOTOR_W-1:0] d1;
    logic signed [jddm_pkg::MOTOR_W-1:0] d2;
    logic signed [jddm_pkg::MOTOR_W-1:0] d2_out;
    logic signed [jddm_pkg::MOTOR_W-1:0] motors [3];

    function automatic logic signed [jddm_pkg::MOTOR_W-1:0] clamp_drive
        (input logic signed [jddm_pkg::MOTOR_W-1:0] v);
        logic signed [jddm_pkg::MOTOR_W-1:0] r;
        if (v > jddm_pkg::DRIVE_LIMIT)
        begin
            r = jddm_pkg::DRIVE_LIMIT;
        end
        else if (v < -jddm_pkg::DRIVE_LIMIT)
        begin
            r = -jddm_pkg::DRIVE_LIMIT;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Sign-extend to the motor width; sums of two axes fit in 9 bits.
    assign xe   = jddm_pkg::MOTOR_W'(x);
    assign ye   = jddm_pkg::MOTOR_W'(y);
    assign de   = jddm_pkg::MOTOR_W'(drive);
    assign sum  = ye + xe;
    assign diff = ye - xe;

    // Single mode passes the axes through; otherwise mix and clamp.
    assign d1     = cfg.single_mode ? ye : clamp_drive(sum);
    assign d2     = cfg.single_mode ? xe : clamp_drive(diff);
    assign d2_out = cfg.reverse_second ? -d2 : d2;

    // Route to outputs; a later source overrides an earlier one on a shared port.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            motors[i] = '0;
            if (cfg.first_drive_port == jddm_pkg::PORT_W'(i))
            begin
                motors[i] = d1;
            end
            if (cfg.second_drive_port == jddm_pkg::PORT_W'(i))
            begin
                motors[i] = d2_out;
            end
            if (cfg.action_port == jddm_pkg::PORT_W'(i))
            begin
                motors[i] = de;
            end
        end
    end

    assign motor_a = motors[0];
    assign motor_b = motors[1];
    assign motor_c = motors[2];

endmodule

[rtl/core/joystick_differential_drive_mixer_top.sv]
// Top level of the joystick differential drive mixer.
// The mixer takes one joystick sample per clock cycle unless the result side stalls, and
// returns one result per sample: the sample is captured in an input register, and when it
// moves on, the shaped axes, the updated action level and the routed motor values are
// written into the result register, from which the result is offered. The action level
// and drive registers update as a sample moves into the result register, so consecutive
// samples see each other's effect in order. The input side keeps accepting while a
// finished result waits, as long as the input register is empty or can move forward.
// Configuration writes are always accepted.
`include "assert_macros.svh"

module joystick_differential_drive_mixer_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jddm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jddm_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Sample channel.
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [jddm_pkg::RAW_W-1:0]           joy_x,
    input  logic [jddm_pkg::RAW_W-1:0]           joy_y,
    input  logic                                 key_down,
    input  logic                                 key_up,
    input  logic                                 key_reverse,
    input  logic                                 key_forward,
    // Result channel.
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [jddm_pkg::MOTOR_W-1:0]  motor_a,
    output logic signed [jddm_pkg::MOTOR_W-1:0]  motor_b,
    output logic signed [jddm_pkg::MOTOR_W-1:0]  motor_c,
    output logic signed [jddm_pkg::AXIS_W-1:0]   shaped_x,
    output logic signed [jddm_pkg::AXIS_W-1:0]   shaped_y,
    output logic [jddm_pkg::LEVEL_W-1:0]         level_now
);

    jddm_pkg::cfg_t                      cfg;
    logic                                in_vld_reg;
    logic [jddm_pkg::RAW_W-1:0]          joy_x_reg;
    logic [jddm_pkg::RAW_W-1:0]          joy_y_reg;
    jddm_pkg::keys_t                     keys_reg;
    logic                                out_vld_reg;
    logic                                advance;
    logic                                in_take;

    logic signed [jddm_pkg::AXIS_W-1:0]  shaped_x_next;
    logic signed [jddm_pkg::AXIS_W-1:0]  shaped_y_next;
    logic [jddm_pkg::LEVEL_W-1:0]        level_next;
    logic signed [jddm_pkg::AXIS_W-1:0]  drive_next;
    logic signed [jddm_pkg::MOTOR_W-1:0] motor_a_next;
    logic signed [jddm_pkg::MOTOR_W-1:0] motor_b_next;
    logic signed [jddm_pkg::MOTOR_W-1:0] motor_c_next;

    logic signed [jddm_pkg::MOTOR_W-1:0] motor_a_reg;
    logic signed [jddm_pkg::MOTOR_W-1:0] motor_b_reg;
    logic signed [jddm_pkg::MOTOR_W-1:0] motor_c_reg;
    logic signed [jddm_pkg::AXIS_W-1:0]  shaped_x_reg;
    logic signed [jddm_pkg::AXIS_W-1:0]  shaped_y_reg;
    logic [jddm_pkg::LEVEL_W-1:0]        level_now_reg;

    jddm_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline flow: the input stage moves on when the result register is free or drained.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            joy_x_reg            <= joy_x;
            joy_y_reg            <= joy_y;
            keys_reg.key_down    <= key_down;
            keys_reg.key_up      <= key_up;
            keys_reg.key_reverse <= key_reverse;
            keys_reg.key_forward <= key_forward;
        end
    end

    jddm_shape u_shape_x
    (
        .raw    (joy_x_reg),
        .tilt   (cfg.control_mode),
        .shaped (shaped_x_next)
    );

    jddm_shape u_shape_y
    (
        .raw    (joy_y_reg),
        .tilt   (cfg.control_mode),
        .shaped (shaped_y_next)
    );

    jddm_action u_action
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tilt      (cfg.control_mode),
        .keys      (keys_reg),
        .level_now (level_next),
        .drive_now (drive_next)
    );

    jddm_mix u_mix
    (
        .x       (shaped_x_next),
        .y       (shaped_y_next),
        .drive   (drive_next),
        .cfg     (cfg),
        .motor_a (motor_a_next),
        .motor_b (motor_b_next),
        .motor_c (motor_c_next)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            motor_a_reg   <= motor_a_next;
            motor_b_reg   <= motor_b_next;
            motor_c_reg   <= motor_c_next;
            shaped_x_reg  <= shaped_x_next;
            shaped_y_reg  <= shaped_y_next;
            level_now_reg <= level_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign motor_a   = motor_a_reg;
    assign motor_b   = motor_b_reg;
    assign motor_c   = motor_c_reg;
    assign shaped_x  = shaped_x_reg;
    assign shaped_y  = shaped_y_reg;
    assign level_now = level_now_reg;

    `JDDM_ASSERT_IMPLIES(a_ready_when_empty, !out_vld_reg, in_ready, "input stalled when empty")
    `JDDM_ASSERT_NEXT(a_advance_fills, advance, out_vld_reg, "result lost after advance")
    `JDDM_ASSERT_NEXT(a_stall_keeps_input, in_vld_reg && !advance, in_vld_reg, "request dropped")

endmodule
